### sv/mesh_bounding_box_and_sphere_unit_defines.svh
// ----------------------------------------------------------------------------
// Mesh bounding box and sphere unit - assertion macros
// Implication checks on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MESH_BOUNDING_BOX_AND_SPHERE_UNIT_DEFINES_SVH
`define MESH_BOUNDING_BOX_AND_SPHERE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MBBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MBBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MBBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/mbbs_pkg.sv
// ----------------------------------------------------------------------------
// mbbs_pkg
// Types, widths and codes shared by the bounding box and sphere unit.
// ----------------------------------------------------------------------------
package mbbs_pkg;

  localparam int MAX_VERTICES_DEF = 1024;

  localparam int COORD_W = 24;
  localparam int ADIFF_W = COORD_W + 1;        // |p - c| fits 25 bits
  localparam int DSQ_W   = 2 * ADIFF_W;        // squared distance
  localparam int ROOT_W  = DSQ_W / 2;          // floor square root
  localparam int VC_W    = 11;

  localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COORD_W-1:0] extent_t;
  typedef coord_t      [2:0]         coord3_t;
  typedef extent_t     [2:0]         extent3_t;
  typedef logic        [DSQ_W-1:0]   dsq_t;
  typedef logic        [ROOT_W-1:0]  root_t;
  typedef logic        [VC_W-1:0]    vcount_t;

  // input word
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   last_vertex;
  } in_word_t;

  // result word
  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    extent_t extent_x;
    extent_t extent_y;
    extent_t extent_z;
    root_t   radius;
  } out_word_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_FIN,
    ST_SQRT_GO,
    ST_SQRT_WAIT
  } state_t;

  // distance unit operations
  typedef enum logic [2:0] {
    DOP_IDLE,
    DOP_CLEAR,
    DOP_DIFF,
    DOP_MUL_X,
    DOP_MUL_Y,
    DOP_MUL_Z,
    DOP_FIN
  } dist_op_t;

  // square root handshake
  typedef struct packed {
    logic start;
  } sqrt_ctl_t;

  typedef struct packed {
    logic busy;
  } sqrt_sts_t;

endpackage

### sv/mesh_bounding_box_and_sphere_unit.sv
// ----------------------------------------------------------------------------
// mesh_bounding_box_and_sphere_unit
// Axis-aligned box and center-based bounding sphere of a streamed mesh.
// ----------------------------------------------------------------------------
//   channel   ports                       word / data
//   input     in_valid, in_stall          in_word   (in_word_t)
//   result    out_valid, out_stall        out_word  (out_word_t)
//   config    cfg_we                      cfg_wdata (vertex_count)
//
// Loading takes one position word per cycle. After the last word the store is
// walked for the radius: a setup step, then read, difference, x/y/z multiply
// and finish steps per used vertex (min(vertex_count, positions) of them), then
// a bit-serial square root and the result load. Input is stalled during that
// pass, which also holds at its end while the previous result word is still stalled.
// Reset is synchronous, active low; vertex_count resets to 1024.
// ----------------------------------------------------------------------------
`include "mesh_bounding_box_and_sphere_unit_defines.svh"

module mesh_bounding_box_and_sphere_unit
  import mbbs_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  vcount_t   cfg_wdata
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int LW = (CW > VC_W) ? CW : VC_W;

  state_t    state_r, state_nxt;
  vcount_t   vcount_r;
  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] len_c;
  logic [CW-1:0] idx_inc;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  logic      in_acc;
  logic      out_free;
  logic      store_we;
  logic      store_re;
  logic      out_load;
  dist_op_t  dist_op;
  sqrt_ctl_t sq_ctl;
  sqrt_sts_t sq_sts;

  coord3_t   pos;
  coord3_t   rd_pos;
  coord3_t   center;
  extent3_t  extent;
  dsq_t      best;
  root_t     root;

  assign pos      = {in_word.pos_z, in_word.pos_y, in_word.pos_x};
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_inc  = idx_r + CW'(1);

  // positions used for the radius
  always_comb begin
    if (LW'(vcount_r) < LW'(seen_r)) begin
      len_c = CW'(vcount_r);
    end else begin
      len_c = seen_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_acc && in_word.last_vertex) state_nxt = ST_SETUP;
      ST_SETUP:     state_nxt = (len_c == '0) ? ST_SQRT_GO : ST_READ;
      ST_READ:      state_nxt = ST_DIFF;
      ST_DIFF:      state_nxt = ST_MUL_X;
      ST_MUL_X:     state_nxt = ST_MUL_Y;
      ST_MUL_Y:     state_nxt = ST_MUL_Z;
      ST_MUL_Z:     state_nxt = ST_FIN;
      ST_FIN:       state_nxt = (idx_inc == len_r) ? ST_SQRT_GO : ST_READ;
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (!sq_sts.busy && out_free) state_nxt = ST_LOAD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    store_we     = 1'b0;
    store_re     = 1'b0;
    dist_op      = DOP_IDLE;
    sq_ctl.start = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        store_we = in_acc && (seen_r < CW'(MAX_VERTICES));
      end
      ST_SETUP:     dist_op      = DOP_CLEAR;
      ST_READ:      store_re     = 1'b1;
      ST_DIFF:      dist_op      = DOP_DIFF;
      ST_MUL_X:     dist_op      = DOP_MUL_X;
      ST_MUL_Y:     dist_op      = DOP_MUL_Y;
      ST_MUL_Z:     dist_op      = DOP_MUL_Z;
      ST_FIN:       dist_op      = DOP_FIN;
      ST_SQRT_GO:   sq_ctl.start = 1'b1;
      ST_SQRT_WAIT: out_load     = !sq_sts.busy && out_free;
      default: begin
      end
    endcase
  end

  // counters
  always_comb begin
    seen_nxt = seen_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    if (store_we) begin
      seen_nxt = seen_r + CW'(1);
    end
    if (state_r == ST_SETUP) begin
      seen_nxt = '0;
      len_nxt  = len_c;
      idx_nxt  = '0;
    end
    if (state_r == ST_FIN) begin
      idx_nxt = idx_inc;
    end
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vcount_r    <= VC_RESET;
      seen_r      <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.center_x <= center[0];
      out_word_r.center_y <= center[1];
      out_word_r.center_z <= center[2];
      out_word_r.extent_x <= extent[0];
      out_word_r.extent_y <= extent[1];
      out_word_r.extent_z <= extent[2];
      out_word_r.radius   <= root;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  mbbs_store #(
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (seen_r[AW-1:0]),
    .wdata (pos),
    .re    (store_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_pos)
  );

  mbbs_range u_range (
    .clk    (clk),
    .upd_en (in_acc),
    .first  (seen_r == '0),
    .pos    (pos),
    .center (center),
    .extent (extent)
  );

  mbbs_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (dist_op),
    .sample (rd_pos),
    .center (center),
    .best   (best)
  );

  mbbs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sq_ctl),
    .value (best),
    .sts   (sq_sts),
    .root  (root)
  );

  // checks
  `MBBS_ASSERT_IMP(a_read_in_range, clk, rst_n, state_r == ST_READ, idx_r < len_r,
                   "read past used positions")
  `MBBS_ASSERT_IMP(a_sqrt_idle_start, clk, rst_n, sq_ctl.start, !sq_sts.busy,
                   "square root restarted while busy")
  `MBBS_ASSERT_NXT(a_last_starts_pass, clk, rst_n, in_acc && in_word.last_vertex,
                   state_r == ST_SETUP && in_stall, "last word did not start the pass")
  `MBBS_ASSERT_IMP(a_load_when_free, clk, rst_n, out_load, !out_valid_r || !out_stall,
                   "result word overwritten")

endmodule

### sv/mbbs_store.sv
// ----------------------------------------------------------------------------
// mbbs_store
// Position memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbbs_store
  import mbbs_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  coord3_t       wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output coord3_t       rdata
);

  coord3_t mem [0:DEPTH-1];
  coord3_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/mbbs_range.sv
// ----------------------------------------------------------------------------
// mbbs_range
// Per-axis running min/max; registered box center and extent.
// ----------------------------------------------------------------------------
module mbbs_range
  import mbbs_pkg::*;
(
  input  logic     clk,
  input  logic     upd_en,
  input  logic     first,
  input  coord3_t  pos,
  output coord3_t  center,
  output extent3_t extent
);

  coord3_t  lo_r;
  coord3_t  hi_r;
  coord3_t  center_r;
  extent3_t extent_r;

  // min/max tracking, first word of a mesh loads both
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (upd_en) begin
        if (first || ($signed(pos[k]) < $signed(lo_r[k]))) begin
          lo_r[k] <= pos[k];
        end
        if (first || ($signed(pos[k]) > $signed(hi_r[k]))) begin
          hi_r[k] <= pos[k];
        end
      end
    end
  end

  // center = floor((lo + hi) / 2), extent = hi - lo
  always_ff @(posedge clk) begin
    logic [COORD_W:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = {lo_r[k][COORD_W-1], lo_r[k]} + {hi_r[k][COORD_W-1], hi_r[k]};
      center_r[k] <= sum[COORD_W:1];
      extent_r[k] <= hi_r[k] - lo_r[k];
    end
  end

  assign center = center_r;
  assign extent = extent_r;

endmodule

### sv/mbbs_dist.sv
// ----------------------------------------------------------------------------
// mbbs_dist
// Squared center distance with one shared multiplier, stepped per axis,
// and the running maximum over the vertices of the pass.
// ----------------------------------------------------------------------------
module mbbs_dist
  import mbbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dist_op_t op,
  input  coord3_t  sample,
  input  coord3_t  center,
  output dsq_t     best
);

  logic [ADIFF_W-1:0] ad_r [3];
  logic [ADIFF_W-1:0] mul_a;
  dsq_t               prod;
  dsq_t               p_r;
  dsq_t               acc_r;
  dsq_t               best_r;
  dsq_t               sum;

  // operand select for the shared multiplier
  always_comb begin
    unique case (op)
      DOP_MUL_Y: mul_a = ad_r[1];
      DOP_MUL_Z: mul_a = ad_r[2];
      default:   mul_a = ad_r[0];
    endcase
  end

  assign prod = mul_a * mul_a;
  assign sum  = acc_r + p_r;

  // absolute differences per axis
  always_ff @(posedge clk) begin
    logic signed [ADIFF_W-1:0] d;
    if (op == DOP_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        d = ADIFF_W'(sample[k]) - ADIFF_W'(center[k]);
        ad_r[k] <= d[ADIFF_W-1] ? ADIFF_W'(-d) : ADIFF_W'(d);
      end
    end
  end

  // product and accumulator
  always_ff @(posedge clk) begin
    unique case (op)
      DOP_MUL_X: begin
        p_r <= prod;
      end
      DOP_MUL_Y: begin
        acc_r <= p_r;
        p_r   <= prod;
      end
      DOP_MUL_Z: begin
        acc_r <= sum;
        p_r   <= prod;
      end
      default: begin
      end
    endcase
  end

  // largest squared distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (op == DOP_CLEAR) begin
      best_r <= '0;
    end else if ((op == DOP_FIN) && (sum > best_r)) begin
      best_r <= sum;
    end
  end

  assign best = best_r;

endmodule

### sv/mbbs_isqrt.sv
// ----------------------------------------------------------------------------
// mbbs_isqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mbbs_isqrt
  import mbbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_ctl_t ctl,
  input  dsq_t      value,
  output sqrt_sts_t sts,
  output root_t     root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  dsq_t             val_r;
  logic [REM_W-1:0] rem_r;
  root_t            root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // one digit step
  assign rem_sh = {rem_r[REM_W-3:0], val_r[DSQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[DSQ_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign root     = root_r;

endmodule
